@@ rtl/pmid_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmid_pkg
// Widths, limits and register indexes shared by the distance unit and its checker.
// ----------------------------------------------------------------------------
package pmid_pkg;

    localparam int IN_W      = 24;
    localparam int N_IN      = 9;
    localparam int S_DATA_W  = IN_W * N_IN;
    localparam int COMP_W    = 21;
    localparam int ROW_W     = 3 * COMP_W;
    localparam int INV_FRAC  = 18;
    localparam int V_W       = 40;
    localparam int PROD_W    = 61;
    localparam int DIFF_W    = 62;
    localparam int ACC_W     = 64;
    localparam int CAND_W    = 32;
    localparam int SQ_W      = 60;
    localparam int BEST_W    = 63;
    localparam int ROOT_W    = 64;
    localparam int DIST_W    = 25;
    localparam int M_DATA_W  = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [DIFF_W-1:0] VEC_LIMIT  = DIFF_W'(64'sd549755813887);
    localparam logic signed [V_W-1:0]    COMP_LIMIT = V_W'(64'sd1073741824);
    localparam logic [BEST_W-1:0]        SQ_CAP     = BEST_W'(64'd1) << 62;
    localparam logic [DIST_W-1:0]        DIST_MAX   = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LAT_A,
        REG_LAT_B,
        REG_LAT_C,
        REG_INV_A,
        REG_INV_B,
        REG_INV_C,
        REG_DIMS,
        REG_EXHAUST
    } cfg_index_t;

endpackage
`default_nettype wire

@@ rtl/periodic_minimum_image_distance_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_minimum_image_distance_unit
// Minimum image distance: axis reduction and translation search on one
// shared multiplier and one squaring stage, then a bit-serial square root.
// ----------------------------------------------------------------------------
// Throughput: one request at a time; s_tready is high only in idle, so a new request
//   is taken only once the previous result has been issued. The candidate sweep
//   (one per cycle) and the 32-step root set the time; a result held by m_tready
//   delays the next.
// Reset: synchronous, active low; registers take their documented values.
module periodic_minimum_image_distance_unit
    import pmid_pkg::*;
#(
    parameter int SEARCH_RANGE = 3,
    parameter int FRAC_BITS    = 14
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z, shift_x, shift_y, shift_z
    input  wire logic [S_DATA_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // distance, zero fill
    output logic [M_DATA_W-1:0]       m_tdata,
    // improved
    output logic                      m_tuser,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ROW_W-1:0]     cfg_data
);

    localparam int SHIFT  = FRAC_BITS + INV_FRAC;
    localparam int CNT_W  = $clog2(2 * SEARCH_RANGE + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(2 * SEARCH_RANGE);
    localparam logic signed [ACC_W-1:0] HALF = (ACC_W'(64'sd1) <<< (SHIFT - 1)) - 1;
    localparam logic signed [CAND_W-1:0] RANGE_S = CAND_W'(SEARCH_RANGE);

    typedef enum logic [3:0] {
        ST_IDLE, ST_RED_CHECK, ST_RED_FMUL, ST_RED_FACC, ST_RED_ROUND,
        ST_RED_SMUL, ST_RED_SUB, ST_NORM, ST_SEARCH, ST_DRAIN, ST_SQRT, ST_OUT
    } state_t;

    state_t state_reg;

    logic [ROW_W-1:0] lattice_reg [3];
    logic [ROW_W-1:0] inverse_reg [3];
    logic [1:0]       dims_reg;
    logic             exhaust_reg;

    logic signed [COMP_W-1:0] lat [3][3];
    logic signed [COMP_W-1:0] inv [3][3];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                lat[r][k] = $signed(lattice_reg[r][COMP_W*k +: COMP_W]);
                inv[r][k] = $signed(inverse_reg[r][COMP_W*k +: COMP_W]);
            end
        end
    end

    // displacement and reduction
    logic signed [CAND_W-1:0] d_reg [3];
    logic signed [V_W-1:0]    v_reg [3];
    logic signed [ACC_W-1:0]  f_reg;
    logic signed [V_W-1:0]    n_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [1:0]               ax_reg;
    logic [1:0]               k_reg;

    logic signed [V_W-1:0]    mul_a;
    logic signed [COMP_W-1:0] mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [ACC_W-1:0]  f_round;
    logic signed [ACC_W-1:0]  n_full;
    logic signed [DIFF_W-1:0] diff;
    logic signed [V_W-1:0]    v_next;
    logic signed [CAND_W-1:0] d_in [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            d_in[k] = $signed(s_tdata[IN_W*(6+k) +: IN_W])
                    + $signed(s_tdata[IN_W*(3+k) +: IN_W])
                    - $signed(s_tdata[IN_W*k +: IN_W]);
        end
    end

    assign mul_a   = (state_reg == ST_RED_FMUL) ? v_reg[k_reg] : n_reg;
    assign mul_b   = (state_reg == ST_RED_FMUL) ? inv[ax_reg][k_reg] : lat[ax_reg][k_reg];
    assign mul_p   = mul_a * mul_b;
    assign f_round = f_reg + HALF;
    assign n_full  = f_round >>> SHIFT;
    assign diff    = v_reg[k_reg] - prod_reg;

    always_comb begin
        if (diff > VEC_LIMIT) begin
            v_next = VEC_LIMIT[V_W-1:0];
        end else if (diff < -VEC_LIMIT) begin
            v_next = V_W'(-VEC_LIMIT);
        end else begin
            v_next = diff[V_W-1:0];
        end
    end

    // reduced-vector length guard
    logic norm_cap;
    always_comb begin
        norm_cap = 1'b0;
        for (int k = 0; k < 3; k++) begin
            if (v_reg[k] >= COMP_LIMIT || v_reg[k] <= -COMP_LIMIT) begin
                norm_cap = 1'b1;
            end
        end
    end

    // candidate generator
    logic signed [CAND_W-1:0] ci_reg [3];
    logic signed [CAND_W-1:0] cj_reg [3];
    logic signed [CAND_W-1:0] gen_reg [3];
    logic [CNT_W-1:0]         cnt_i_reg, cnt_j_reg, cnt_l_reg;
    logic signed [CAND_W-1:0] gen_start [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            gen_start[k] = d_reg[k] - RANGE_S * (lat[0][k] + lat[1][k] + lat[2][k]);
        end
    end

    // squaring pipeline
    logic signed [CAND_W-1:0] c1_reg [3];
    logic                     c1_valid_reg, c1_first_reg, c1_cap_reg;
    logic [SQ_W-1:0]          sq_reg [3];
    logic                     s2_valid_reg, s2_first_reg, s2_cap_reg;
    logic [BEST_W-1:0]        best_reg;
    logic                     better_reg;
    logic signed [2*CAND_W-1:0] sq_full [3];
    logic [BEST_W-1:0]        sq_sum;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sq_full[k] = c1_reg[k] * c1_reg[k];
        end
    end

    assign sq_sum = s2_cap_reg ? SQ_CAP
                  : BEST_W'(sq_reg[0]) + BEST_W'(sq_reg[1]) + BEST_W'(sq_reg[2]);

    // square root, one result bit per cycle
    logic [ROOT_W-1:0] x_reg, res_reg, one_reg;
    logic [4:0]        it_reg;
    logic [ROOT_W-1:0] trial;

    assign trial = res_reg + one_reg;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lattice_reg[0] <= '0;
            lattice_reg[1] <= '0;
            lattice_reg[2] <= '0;
            inverse_reg[0] <= '0;
            inverse_reg[1] <= '0;
            inverse_reg[2] <= '0;
            dims_reg       <= 2'd3;
            exhaust_reg    <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index_t'(cfg_index))
                REG_LAT_A:   lattice_reg[0] <= cfg_data;
                REG_LAT_B:   lattice_reg[1] <= cfg_data;
                REG_LAT_C:   lattice_reg[2] <= cfg_data;
                REG_INV_A:   inverse_reg[0] <= cfg_data;
                REG_INV_B:   inverse_reg[1] <= cfg_data;
                REG_INV_C:   inverse_reg[2] <= cfg_data;
                REG_DIMS:    dims_reg       <= cfg_data[1:0];
                REG_EXHAUST: exhaust_reg    <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid     <= 1'b0;
            c1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_OUT && (!m_tvalid || m_tready)) begin
                m_tvalid <= 1'b1;
            end else if (m_tvalid && m_tready) begin
                m_tvalid <= 1'b0;
            end

            c1_valid_reg <= (state_reg == ST_NORM) || (state_reg == ST_SEARCH);
            s2_valid_reg <= c1_valid_reg;
            s2_first_reg <= c1_first_reg;
            s2_cap_reg   <= c1_cap_reg;
            for (int k = 0; k < 3; k++) begin
                sq_reg[k] <= sq_full[k][SQ_W-1:0];
            end
            if (s2_valid_reg) begin
                if (s2_first_reg) begin
                    best_reg   <= sq_sum;
                    better_reg <= 1'b0;
                end else if (sq_sum < best_reg) begin
                    best_reg   <= sq_sum;
                    better_reg <= 1'b1;
                end
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        for (int k = 0; k < 3; k++) begin
                            d_reg[k] <= d_in[k];
                            v_reg[k] <= V_W'(d_in[k]);
                        end
                        f_reg     <= '0;
                        ax_reg    <= '0;
                        k_reg     <= '0;
                        state_reg <= ST_RED_CHECK;
                    end
                end
                ST_RED_CHECK: begin
                    state_reg <= (ax_reg < dims_reg) ? ST_RED_FMUL : ST_NORM;
                end
                ST_RED_FMUL: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_RED_FACC;
                end
                ST_RED_FACC: begin
                    f_reg <= f_reg + prod_reg;
                    if (k_reg == 2'd2) begin
                        k_reg     <= '0;
                        state_reg <= ST_RED_ROUND;
                    end else begin
                        k_reg     <= k_reg + 2'd1;
                        state_reg <= ST_RED_FMUL;
                    end
                end
                ST_RED_ROUND: begin
                    n_reg     <= n_full[V_W-1:0];
                    state_reg <= ST_RED_SMUL;
                end
                ST_RED_SMUL: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_RED_SUB;
                end
                ST_RED_SUB: begin
                    v_reg[k_reg] <= v_next;
                    if (k_reg == 2'd2) begin
                        k_reg     <= '0;
                        ax_reg    <= ax_reg + 2'd1;
                        f_reg     <= '0;
                        state_reg <= ST_RED_CHECK;
                    end else begin
                        k_reg     <= k_reg + 2'd1;
                        state_reg <= ST_RED_SMUL;
                    end
                end
                ST_NORM: begin
                    for (int k = 0; k < 3; k++) begin
                        c1_reg[k]  <= v_reg[k][CAND_W-1:0];
                        ci_reg[k]  <= gen_start[k];
                        cj_reg[k]  <= gen_start[k];
                        gen_reg[k] <= gen_start[k];
                    end
                    c1_first_reg <= 1'b1;
                    c1_cap_reg   <= norm_cap;
                    cnt_i_reg    <= '0;
                    cnt_j_reg    <= '0;
                    cnt_l_reg    <= '0;
                    state_reg    <= exhaust_reg ? ST_SEARCH : ST_DRAIN;
                end
                ST_SEARCH: begin
                    for (int k = 0; k < 3; k++) begin
                        c1_reg[k] <= gen_reg[k];
                    end
                    c1_first_reg <= 1'b0;
                    c1_cap_reg   <= 1'b0;
                    if (cnt_l_reg != CNT_LAST) begin
                        cnt_l_reg <= cnt_l_reg + 1'b1;
                        for (int k = 0; k < 3; k++) begin
                            gen_reg[k] <= gen_reg[k] + lat[2][k];
                        end
                    end else if (cnt_j_reg != CNT_LAST) begin
                        cnt_l_reg <= '0;
                        cnt_j_reg <= cnt_j_reg + 1'b1;
                        for (int k = 0; k < 3; k++) begin
                            cj_reg[k]  <= cj_reg[k] + lat[1][k];
                            gen_reg[k] <= cj_reg[k] + lat[1][k];
                        end
                    end else if (cnt_i_reg != CNT_LAST) begin
                        cnt_l_reg <= '0;
                        cnt_j_reg <= '0;
                        cnt_i_reg <= cnt_i_reg + 1'b1;
                        for (int k = 0; k < 3; k++) begin
                            ci_reg[k]  <= ci_reg[k] + lat[0][k];
                            cj_reg[k]  <= ci_reg[k] + lat[0][k];
                            gen_reg[k] <= ci_reg[k] + lat[0][k];
                        end
                    end else begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!c1_valid_reg && !s2_valid_reg) begin
                        x_reg     <= ROOT_W'(best_reg);
                        res_reg   <= '0;
                        one_reg   <= ROOT_W'(64'd1) << 62;
                        it_reg    <= '0;
                        state_reg <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (x_reg >= trial) begin
                        x_reg   <= x_reg - trial;
                        res_reg <= (res_reg >> 1) + one_reg;
                    end else begin
                        res_reg <= res_reg >> 1;
                    end
                    one_reg <= one_reg >> 2;
                    it_reg  <= it_reg + 5'd1;
                    if (it_reg == 5'd31) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_tvalid || m_tready) begin
                        m_tdata   <= M_DATA_W'((res_reg > ROOT_W'(DIST_MAX))
                                     ? DIST_MAX : res_reg[DIST_W-1:0]);
                        m_tuser   <= better_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ rtl/pmid_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmid_checker
// Port-level checks of the distance unit, bound to the top level.
// ----------------------------------------------------------------------------
module pmid_checker
    import pmid_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_tvalid,
    input wire logic                s_tready,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata,
    input wire logic                m_tuser
);

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("unit not idle after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready && !$rose(m_tvalid))
        else $error("request taken while busy or result too early");

    a_result_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready)
        else $error("result issued without returning to idle");

endmodule

bind periodic_minimum_image_distance_unit pmid_checker u_pmid_checker (.*);
`default_nettype wire

@@ verif/tb_periodic_minimum_image_distance_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_periodic_minimum_image_distance_unit
// Self-checking bench for the minimum image distance unit: programs lattice
// and inverse rows, streams atom pairs and compares distance and improved flag
// against a local fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_periodic_minimum_image_distance_unit;
    import pmid_pkg::*;

    localparam int RANGE = 3;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic [DIST_W-1:0] distance;
        logic              improved;
    } dist_result_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 m_tuser;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ROW_W-1:0]     cfg_data;

    logic [ROW_W-1:0] lat_rows [3];
    logic [ROW_W-1:0] inv_rows [3];
    logic [1:0]       dims_reg;
    logic             exhaust_reg;

    dist_result_t pending_distances [$];
    int           error_count;
    int           idle_cycles;
    bit           sink_stall_enable;

    periodic_minimum_image_distance_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint comp(logic [ROW_W-1:0] row, int k);
        logic signed [COMP_W-1:0] c;
        c = row[COMP_W*k +: COMP_W];
        return longint'(c);
    endfunction

    function automatic longint clamp_v(longint x);
        longint lim;
        lim = 64'sd549755813887;
        if (x > lim) return lim;
        if (x < -lim) return -lim;
        return x;
    endfunction

    function automatic logic [63:0] square_len(longint v [3]);
        logic [63:0] sum;
        logic [63:0] a;
        sum = 0;
        for (int k = 0; k < 3; k++) begin
            a = v[k] < 0 ? -v[k] : v[k];
            if (a >= 64'd1073741824) return 64'd1 << 62;
            sum += a * a;
        end
        return sum;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic dist_result_t predict_distance(logic [S_DATA_W-1:0] data);
        longint       d [3];
        longint       v [3];
        longint       cand [3];
        longint       f;
        longint       n;
        longint       half;
        logic [63:0]  best;
        logic [63:0]  s;
        logic signed [IN_W-1:0] p, q, r;
        dist_result_t res;
        half = (64'sd1 << 31) - 1;
        res.improved = 1'b0;
        for (int k = 0; k < 3; k++) begin
            p = data[IN_W*k +: IN_W];
            q = data[IN_W*(3+k) +: IN_W];
            r = data[IN_W*(6+k) +: IN_W];
            d[k] = longint'(r) + longint'(q) - longint'(p);
            v[k] = d[k];
        end
        for (int ax = 0; ax < dims_reg; ax++) begin
            f = 0;
            for (int k = 0; k < 3; k++) f += comp(inv_rows[ax], k) * v[k];
            n = (f + half) >>> 32;
            for (int k = 0; k < 3; k++) v[k] = clamp_v(v[k] - n * comp(lat_rows[ax], k));
        end
        best = square_len(v);
        if (exhaust_reg) begin
            for (int i = -RANGE; i <= RANGE; i++)
                for (int j = -RANGE; j <= RANGE; j++)
                    for (int l = -RANGE; l <= RANGE; l++) begin
                        for (int k = 0; k < 3; k++)
                            cand[k] = d[k] + i * comp(lat_rows[0], k)
                                    + j * comp(lat_rows[1], k) + l * comp(lat_rows[2], k);
                        s = square_len(cand);
                        if (s < best) begin
                            best = s;
                            res.improved = 1'b1;
                        end
                    end
        end
        s = int_sqrt(best);
        res.distance = s > 64'd33554431 ? DIST_MAX : s[DIST_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    task automatic write_register(cfg_index_t idx, logic [ROW_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_LAT_A, REG_LAT_B, REG_LAT_C: lat_rows[idx - REG_LAT_A] = value;
            REG_INV_A, REG_INV_B, REG_INV_C: inv_rows[idx - REG_INV_A] = value;
            REG_DIMS:    dims_reg = value[1:0];
            REG_EXHAUST: exhaust_reg = value[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_request(logic [S_DATA_W-1:0] data, bit allow_gap);
        int gap;
        gap = allow_gap ? $urandom_range(0, 13) : 0;
        repeat (gap) @(negedge aclk);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_distances.push_back(predict_distance(data));
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic drain_results();
        while (pending_distances.size() != 0) @(posedge aclk);
        repeat (450) @(posedge aclk);
    endtask

    // Packed row from three signed components.
    function automatic logic [ROW_W-1:0] pack_row(int x, int y, int z);
        return {COMP_W'(z), COMP_W'(y), COMP_W'(x)};
    endfunction

    function automatic logic [S_DATA_W-1:0] random_atoms(int span);
        logic [S_DATA_W-1:0] data;
        for (int k = 0; k < N_IN; k++)
            data[IN_W*k +: IN_W] = IN_W'($urandom_range(0, 2*span) - span);
        return data;
    endfunction

    // Cubic cell of edge a (Q7.14) with its exact inverse where possible.
    task automatic load_cubic_cell(int edge_len, int inv_val);
        write_register(REG_LAT_A, pack_row(edge_len, 0, 0));
        write_register(REG_LAT_B, pack_row(0, edge_len, 0));
        write_register(REG_LAT_C, pack_row(0, 0, edge_len));
        write_register(REG_INV_A, pack_row(inv_val, 0, 0));
        write_register(REG_INV_B, pack_row(0, inv_val, 0));
        write_register(REG_INV_C, pack_row(0, 0, inv_val));
    endtask

    task automatic test_reset_defaults();
        send_request('0, 1'b0);
        send_request(random_atoms(1 << 20), 1'b0);
        drain_results();
    endtask

    task automatic test_directed_extremes();
        logic [S_DATA_W-1:0] data;
        load_cubic_cell(4 << 14, 1 << 16);
        write_register(REG_DIMS, 2'd3);
        write_register(REG_EXHAUST, 1'b1);
        data = '0;
        for (int k = 0; k < N_IN; k++) data[IN_W*k +: IN_W] = {1'b1, {(IN_W-1){1'b0}}};
        send_request(data, 1'b0);
        data = '1 >> 0;
        for (int k = 0; k < N_IN; k++) data[IN_W*k +: IN_W] = {1'b0, {(IN_W-1){1'b1}}};
        send_request(data, 1'b0);
        send_request('1, 1'b0);
        // half-cell tie on x
        data = '0;
        data[IN_W*3 +: IN_W] = IN_W'(2 << 14);
        send_request(data, 1'b0);
        data[IN_W*3 +: IN_W] = IN_W'(-(2 << 14));
        send_request(data, 1'b0);
        drain_results();
        // mismatched inverse: runaway clamp and saturation
        write_register(REG_INV_A, pack_row(-(1 << 20), (1 << 20) - 1, -(1 << 20)));
        write_register(REG_LAT_A, pack_row((1 << 20) - 1, -(1 << 20), (1 << 20) - 1));
        send_request(data, 1'b0);
        for (int k = 0; k < N_IN; k++) data[IN_W*k +: IN_W] = {1'b0, {(IN_W-1){1'b1}}};
        send_request(data, 1'b0);
        drain_results();
        for (int dm = 0; dm < 4; dm++) begin
            write_register(REG_DIMS, 2'(dm));
            write_register(REG_EXHAUST, 1'(dm & 1));
            send_request(random_atoms(1 << 17), 1'b0);
            send_request(random_atoms(1 << 23), 1'b0);
            drain_results();
        end
    endtask

    task automatic test_random_cells(int n_items);
        int edge_len;
        int per_phase;
        per_phase = n_items / 6;
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 5) begin
                for (int r = 0; r < 6; r++)
                    write_register(cfg_index_t'(r), ROW_W'({$urandom, $urandom}));
            end else begin
                edge_len = $urandom_range(1 << 12, (1 << 20) - 1);
                load_cubic_cell(edge_len, int'((64'd1 << 32) / edge_len) & ((1 << 20) - 1));
                if (ph == 2)
                    write_register(REG_LAT_B, pack_row(edge_len / 2, edge_len, 0));
            end
            write_register(REG_DIMS, 2'($urandom_range(0, 3)));
            write_register(REG_EXHAUST, 1'($urandom_range(0, 1)));
            sink_stall_enable = (ph != 1);
            for (int i = 0; i < per_phase; i++) begin
                if (ph == 3 && i == per_phase / 2)
                    while (pending_distances.size() != 0) @(posedge aclk);
                send_request(random_atoms(i % 4 == 0 ? (1 << 23) - 1 : edge_len * 3),
                             ph != 1);
            end
            drain_results();
        end
        sink_stall_enable = 1'b1;
    endtask

    // Result checker and sink stalls.
    always @(posedge aclk) begin
        dist_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_distances.size() == 0) begin
                report_mismatch("unexpected result", m_tdata, 0);
            end else begin
                want = pending_distances.pop_front();
                if (m_tdata[DIST_W-1:0] !== want.distance)
                    report_mismatch("distance", m_tdata[DIST_W-1:0], want.distance);
                if (m_tdata[M_DATA_W-1:DIST_W] !== '0)
                    report_mismatch("fill", m_tdata[M_DATA_W-1:DIST_W], 0);
                if (m_tuser !== want.improved)
                    report_mismatch("improved", m_tuser, want.improved);
            end
        end
    end

    initial begin
        int wait_left;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!sink_stall_enable) begin
                m_tready <= 1'b1;
            end else if (m_tready && m_tvalid) begin
                m_tready <= 1'b0;
            end else if (!m_tready) begin
                wait_left = $urandom_range(0, 13);
                repeat (wait_left) @(negedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
                || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        error_count = 0;
        idle_cycles = 0;
        sink_stall_enable = 1'b1;
        lat_rows = '{default: '0};
        inv_rows = '{default: '0};
        dims_reg = 2'd3;
        exhaust_reg = 1'b1;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_reset_defaults();
        test_directed_extremes();
        test_random_cells(576);
        drain_results();
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/pmid_pkg.sv
rtl/periodic_minimum_image_distance_unit.sv
rtl/pmid_checker.sv
verif/tb_periodic_minimum_image_distance_unit.sv
